@@ rtl/hbs_pkg.sv @@
package hbs_pkg;

  localparam int MAX_GRID = 256;
  localparam int COORD_W  = $clog2(MAX_GRID);
  localparam int ADDR_W   = 2 * COORD_W;
  localparam int DEPTH    = MAX_GRID * MAX_GRID;
  localparam int GRID_W   = 9;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_FILL   = 3'd2,
    OP_SAMPLE = 3'd3,
    OP_NORMAL = 3'd4
  } op_t;

  localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [1:0] CFG_TPM       = 2'd1;
  localparam logic [1:0] CFG_MPT       = 2'd2;
  localparam logic [1:0] CFG_ENABLE    = 2'd3;

  localparam logic [31:0] SCALE_RESET = 32'd65536;
  localparam logic [15:0] Q15_ONE     = 16'd32767;

endpackage

@@ rtl/heightfield_bilinear_sampler.sv @@
// heightfield sampler: a 256 x 256 store of signed q16.16 heights in one
// single-port synchronous ram, with bilinear height and normal sampling.
// in_ channel: one beat per operation, opcode in in_tuser. out_ channel:
// exactly one result beat per operation, out_of_bounds in out_tuser.
// cfg_ channel: register writes, always ready; write only while idle.
// one operation at a time; in_tready is high only while idle, but a result
// waiting in the output register does not hold up the next operation.
// steps of each operation, set by the single ram port and the sequencer:
//   texel write: address, ram access; texel read: address, ram access,
//   capture; unused opcode, out of bounds or disabled: straight to the result,
//   height sample: two 32x32 scale multiplies, four reads, three lerp
//   multiplies, normal: four samples = sixteen reads, normalising shifts,
//   3 squares, 32 square-root steps, three divides; a flat field with zero
//   spacing stops after the four samples,
//   fill: one word per cycle over the whole ram.
// reset: sync, active low; registers take their reset values and the ram
// is swept to zero, a sweep during which no operation is accepted.
// a stalled receiver holds the result; the next one waits in the sequencer.
module heightfield_bilinear_sampler
  import hbs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // texel_x[15:0], texel_z[31:16], height_value[63:32], world_x[95:64],
  // world_z[127:96]
  input  logic [127:0] in_tdata,
  // opcode[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // height_out[31:0], normal_x[47:32], normal_y[63:48], normal_z[79:64]
  output logic [79:0]  out_tdata,
  // out_of_bounds[0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  typedef enum logic [16:0] {
    ST_IDLE   = 17'h00001,
    ST_CLEAR  = 17'h00002,
    ST_TADDR  = 17'h00004,
    ST_TACC   = 17'h00008,
    ST_TCAP   = 17'h00010,
    ST_TMUL   = 17'h00020,
    ST_TCLAMP = 17'h00040,
    ST_ROWS   = 17'h00080,
    ST_READ   = 17'h00100,
    ST_LERP   = 17'h00200,
    ST_NPREP  = 17'h00400,
    ST_NSHIFT = 17'h00800,
    ST_SQ     = 17'h01000,
    ST_SQRT   = 17'h02000,
    ST_DLOAD  = 17'h04000,
    ST_DIV    = 17'h08000,
    ST_DONE   = 17'h10000
  } state_t;

  state_t state_r;

  // configuration
  logic [GRID_W-1:0] grid_size_r;
  logic [31:0]       tpm_r;
  logic [31:0]       mpt_r;
  logic              enabled_r;

  // operation
  logic [2:0]        op_r;
  logic [15:0]       tx_r;
  logic [15:0]       tz_r;
  logic [31:0]       hv_r;
  logic [31:0]       wx_r;
  logic [31:0]       wz_r;

  // memory
  logic [31:0]       mem [DEPTH];
  logic [31:0]       mem_q_r;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [31:0]       mem_wd;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [31:0]       fill_val_r;
  logic              clr_ret_r;
  logic [ADDR_W-1:0] addr_r;

  // sampling
  logic [1:0]         smp_r;
  logic               axis_r;
  logic [COORD_W-1:0] x0_r, z0_r, x1_r;
  logic [15:0]        tfx_r, tfz_r;
  logic [ADDR_W-1:0]  base0_r, base1_r;
  logic [2:0]         rd_cnt_r;
  logic [31:0]        hq_r [4];
  logic [2:0]         lerp_cnt_r;
  logic [31:0]        h0_r, h1_r;
  logic [31:0]        s_r [4];
  logic signed [65:0] prod_r;

  // normal
  logic [32:0]        ax_r, ay_r, az_r, m_r;
  logic               negx_r, negz_r;
  logic [1:0]         sq_cnt_r;
  logic [63:0]        n_r;
  logic [63:0]        r_r;
  logic [4:0]         j_r;
  logic [31:0]        len_r;
  logic [47:0]        rem_r, d_r;
  logic [16:0]        q_r;
  logic [4:0]         div_cnt_r;
  logic [1:0]         comp_r;

  // result
  logic [31:0]        res_h_r;
  logic [15:0]        res_nx_r, res_ny_r, res_nz_r;
  logic               res_oob_r;
  logic               out_valid_r;
  logic [79:0]        out_data_r;
  logic               out_oob_r;

  // effective grid
  logic [GRID_W-1:0]  g_eff;
  logic [COORD_W-1:0] gm1;
  logic               active;

  assign g_eff  = (grid_size_r > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : grid_size_r;
  assign gm1    = COORD_W'(g_eff - GRID_W'(1));
  assign active = enabled_r && (g_eff >= GRID_W'(2));

  // input fields
  logic [15:0] in_x, in_z;
  logic        in_ok;
  assign in_x  = in_tdata[15:0];
  assign in_z  = in_tdata[31:16];
  assign in_ok = (in_x < 16'(g_eff)) && (in_z < 16'(g_eff));

  // sample position of the current sample, 34 bit signed, no wrap
  logic signed [33:0] wx34, wz34, du34, px, pz, pos;
  logic               use_off, pos_pos;
  assign wx34    = $signed({{2{wx_r[31]}}, wx_r});
  assign wz34    = $signed({{2{wz_r[31]}}, wz_r});
  assign du34    = $signed({2'b00, mpt_r});
  assign use_off = (op_r == OP_NORMAL);

  always_comb begin
    px = wx34;
    pz = wz34;
    if (use_off) begin
      case (smp_r)
        2'd0:    px = wx34 + du34;
        2'd1:    px = wx34 - du34;
        2'd2:    pz = wz34 + du34;
        default: pz = wz34 - du34;
      endcase
    end
  end

  assign pos     = axis_r ? pz : px;
  assign pos_pos = !pos[33] && (pos != 34'sd0);

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_nxt;
  logic signed [65:0] prod_sh;
  logic [30:0]        sq_op;

  always_comb begin
    case (sq_cnt_r)
      2'd0:    sq_op = ax_r[30:0];
      2'd1:    sq_op = ay_r[30:0];
      default: sq_op = az_r[30:0];
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_TMUL: begin
        mul_a = $signed({1'b0, pos[31:0]});
        mul_b = $signed({1'b0, tpm_r});
      end
      ST_LERP: begin
        case (lerp_cnt_r)
          3'd0: begin
            mul_a = $signed({hq_r[1][31], hq_r[1]}) - $signed({hq_r[0][31], hq_r[0]});
            mul_b = $signed({17'b0, tfx_r});
          end
          3'd1: begin
            mul_a = $signed({hq_r[3][31], hq_r[3]}) - $signed({hq_r[2][31], hq_r[2]});
            mul_b = $signed({17'b0, tfx_r});
          end
          3'd3: begin
            mul_a = $signed({h1_r[31], h1_r}) - $signed({h0_r[31], h0_r});
            mul_b = $signed({17'b0, tfz_r});
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_SQ: begin
        mul_a = $signed({2'b00, sq_op});
        mul_b = $signed({2'b00, sq_op});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_sh  = prod_r >>> 16;

  // texel coordinate clamp
  logic [64:0] full_u, limit_u, coord_u;
  assign full_u  = {1'b0, prod_r[63:0]} + (pos[32] ? {1'b0, tpm_r, 32'b0} : 65'd0);
  assign limit_u = {25'b0, gm1, 32'b0};
  assign coord_u = !pos_pos ? 65'd0 : ((full_u > limit_u) ? limit_u : full_u);

  // neighbours
  logic [COORD_W:0]  x0p1, z0p1;
  logic [COORD_W-1:0] x1_c, z1_c;
  assign x0p1 = {1'b0, x0_r} + (COORD_W+1)'(1);
  assign z0p1 = {1'b0, z0_r} + (COORD_W+1)'(1);
  assign x1_c = (x0p1 < {1'b0, gm1}) ? x0p1[COORD_W-1:0] : gm1;
  assign z1_c = (z0p1 < {1'b0, gm1}) ? z0p1[COORD_W-1:0] : gm1;

  // read address of the current corner: h00, h10, h01, h11
  logic [ADDR_W-1:0] rd_addr;
  always_comb begin
    case (rd_cnt_r[1:0])
      2'd0:    rd_addr = base0_r + {{COORD_W{1'b0}}, x0_r};
      2'd1:    rd_addr = base0_r + {{COORD_W{1'b0}}, x1_r};
      2'd2:    rd_addr = base1_r + {{COORD_W{1'b0}}, x0_r};
      default: rd_addr = base1_r + {{COORD_W{1'b0}}, x1_r};
    endcase
  end

  // central differences
  logic signed [32:0] dx, dz;
  logic [32:0]        adx, adz, ay_c, m_c;
  assign dx   = $signed({s_r[0][31], s_r[0]}) - $signed({s_r[1][31], s_r[1]});
  assign dz   = $signed({s_r[2][31], s_r[2]}) - $signed({s_r[3][31], s_r[3]});
  assign adx  = dx[32] ? 33'(-dx) : 33'(dx);
  assign adz  = dz[32] ? 33'(-dz) : 33'(dz);
  assign ay_c = {mpt_r, 1'b0};

  always_comb begin
    m_c = (adx > ay_c) ? adx : ay_c;
    if (adz > m_c) m_c = adz;
  end

  // square root step
  logic [63:0] sq_bit, sq_trial, n_nxt, r_nxt;
  logic        sq_ge;
  assign sq_bit   = 64'(1) << {j_r, 1'b0};
  assign sq_trial = r_r + sq_bit;
  assign sq_ge    = (n_r >= sq_trial);
  assign n_nxt    = sq_ge ? (n_r - sq_trial) : n_r;
  assign r_nxt    = sq_ge ? ((r_r >> 1) + sq_bit) : (r_r >> 1);

  // divide step
  logic [30:0] div_mag;
  logic        div_neg;
  logic        dv_ge;
  logic [47:0] rem_nxt;
  logic [16:0] q_nxt;
  logic [15:0] c_sat, c_out;

  always_comb begin
    case (comp_r)
      2'd0:    begin div_mag = ax_r[30:0]; div_neg = negx_r; end
      2'd1:    begin div_mag = ay_r[30:0]; div_neg = 1'b0;   end
      default: begin div_mag = az_r[30:0]; div_neg = negz_r; end
    endcase
  end

  assign dv_ge   = (rem_r >= d_r);
  assign rem_nxt = dv_ge ? (rem_r - d_r) : rem_r;
  assign q_nxt   = {q_r[15:0], dv_ge};
  assign c_sat   = (q_nxt > 17'(Q15_ONE)) ? Q15_ONE : q_nxt[15:0];
  assign c_out   = div_neg ? 16'(-c_sat) : c_sat;

  // memory port
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = rd_addr;
    mem_wd   = hv_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
        mem_wd   = fill_val_r;
      end
      ST_TACC: begin
        mem_addr = addr_r;
        mem_we   = (op_r == OP_WRITE);
        mem_re   = (op_r == OP_READ);
      end
      ST_READ: begin
        mem_re = (rd_cnt_r < 3'd4);
      end
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) mem_q_r <= mem[mem_addr];
  end

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= '0;
      tpm_r       <= SCALE_RESET;
      mpt_r       <= SCALE_RESET;
      enabled_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRID_SIZE: grid_size_r <= cfg_data[GRID_W-1:0];
        CFG_TPM:       tpm_r       <= cfg_data;
        CFG_MPT:       mpt_r       <= cfg_data;
        CFG_ENABLE:    enabled_r   <= cfg_data[0];
        default:       enabled_r   <= enabled_r;
      endcase
    end
  end

  // sequencer
  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      fill_val_r  <= '0;
      clr_ret_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // the done state loads the next beat itself
      if (out_valid_r && out_tready && state_r != ST_DONE) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            op_r      <= in_tuser;
            tx_r      <= in_x;
            tz_r      <= in_z;
            hv_r      <= in_tdata[63:32];
            wx_r      <= in_tdata[95:64];
            wz_r      <= in_tdata[127:96];
            res_h_r   <= '0;
            res_nx_r  <= '0;
            res_ny_r  <= (in_tuser == OP_NORMAL && !active) ? Q15_ONE : 16'd0;
            res_nz_r  <= '0;
            res_oob_r <= (in_tuser == OP_WRITE || in_tuser == OP_READ) && !in_ok;
            smp_r     <= '0;
            axis_r    <= 1'b0;
            case (in_tuser)
              OP_WRITE, OP_READ: begin
                state_r <= in_ok ? ST_TADDR : ST_DONE;
              end
              OP_FILL: begin
                fill_val_r <= in_tdata[63:32];
                clr_cnt_r  <= '0;
                clr_ret_r  <= 1'b1;
                state_r    <= ST_CLEAR;
              end
              OP_SAMPLE: begin
                state_r <= active ? ST_TMUL : ST_DONE;
              end
              OP_NORMAL: begin
                state_r <= active ? ST_TMUL : ST_DONE;
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end

        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (&clr_cnt_r) state_r <= clr_ret_r ? ST_DONE : ST_IDLE;
        end

        ST_TADDR: begin
          addr_r  <= ADDR_W'({{COORD_W{1'b0}}, tz_r[COORD_W-1:0]} * ADDR_W'(g_eff))
                     + {{COORD_W{1'b0}}, tx_r[COORD_W-1:0]};
          state_r <= ST_TACC;
        end

        ST_TACC: begin
          state_r <= (op_r == OP_READ) ? ST_TCAP : ST_DONE;
        end

        ST_TCAP: begin
          res_h_r <= mem_q_r;
          state_r <= ST_DONE;
        end

        ST_TMUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_TCLAMP;
        end

        ST_TCLAMP: begin
          if (!axis_r) begin
            x0_r    <= coord_u[32+COORD_W-1:32];
            tfx_r   <= coord_u[31:16];
            axis_r  <= 1'b1;
            state_r <= ST_TMUL;
          end else begin
            z0_r    <= coord_u[32+COORD_W-1:32];
            tfz_r   <= coord_u[31:16];
            state_r <= ST_ROWS;
          end
        end

        ST_ROWS: begin
          x1_r     <= x1_c;
          base0_r  <= ADDR_W'({{COORD_W{1'b0}}, z0_r} * ADDR_W'(g_eff));
          base1_r  <= ADDR_W'({{COORD_W{1'b0}}, z1_c} * ADDR_W'(g_eff));
          rd_cnt_r <= '0;
          state_r  <= ST_READ;
        end

        ST_READ: begin
          // ram data is registered: each step captures the word addressed in the step before
          if (rd_cnt_r != 3'd0) hq_r[rd_cnt_r[1:0] - 2'd1] <= mem_q_r;
          rd_cnt_r <= rd_cnt_r + 3'd1;
          if (rd_cnt_r == 3'd4) begin
            lerp_cnt_r <= '0;
            state_r    <= ST_LERP;
          end
        end

        ST_LERP: begin
          lerp_cnt_r <= lerp_cnt_r + 3'd1;
          prod_r     <= prod_nxt;
          case (lerp_cnt_r)
            3'd1: h0_r <= hq_r[0] + prod_sh[31:0];
            3'd2: h1_r <= hq_r[2] + prod_sh[31:0];
            3'd4: begin
              s_r[smp_r] <= h0_r + prod_sh[31:0];
              axis_r     <= 1'b0;
              if (op_r == OP_SAMPLE) begin
                res_h_r <= h0_r + prod_sh[31:0];
                state_r <= ST_DONE;
              end else if (smp_r != 2'd3) begin
                smp_r   <= smp_r + 2'd1;
                state_r <= ST_TMUL;
              end else begin
                state_r <= ST_NPREP;
              end
            end
            default: h1_r <= h1_r;
          endcase
        end

        ST_NPREP: begin
          ax_r   <= adx;
          ay_r   <= ay_c;
          az_r   <= adz;
          m_r    <= m_c;
          negx_r <= !dx[32] && (dx != 33'sd0);
          negz_r <= !dz[32] && (dz != 33'sd0);
          if (m_c == 33'd0) begin
            res_ny_r <= Q15_ONE;
            state_r  <= ST_DONE;
          end else begin
            state_r <= ST_NSHIFT;
          end
        end

        ST_NSHIFT: begin
          if (m_r[32:31] != 2'b00) begin
            ax_r <= ax_r >> 1;
            ay_r <= ay_r >> 1;
            az_r <= az_r >> 1;
            m_r  <= m_r >> 1;
          end else if (!m_r[30]) begin
            ax_r <= ax_r << 1;
            ay_r <= ay_r << 1;
            az_r <= az_r << 1;
            m_r  <= m_r << 1;
          end else begin
            sq_cnt_r <= '0;
            n_r      <= '0;
            state_r  <= ST_SQ;
          end
        end

        ST_SQ: begin
          prod_r   <= prod_nxt;
          sq_cnt_r <= sq_cnt_r + 2'd1;
          if (sq_cnt_r != 2'd0) n_r <= n_r + prod_r[63:0];
          if (sq_cnt_r == 2'd3) begin
            r_r     <= '0;
            j_r     <= 5'd31;
            state_r <= ST_SQRT;
          end
        end

        ST_SQRT: begin
          n_r <= n_nxt;
          r_r <= r_nxt;
          j_r <= j_r - 5'd1;
          if (j_r == 5'd0) begin
            len_r   <= r_nxt[31:0];
            comp_r  <= '0;
            state_r <= ST_DLOAD;
          end
        end

        ST_DLOAD: begin
          // round half up: add half the divisor before the divide
          rem_r     <= {2'b00, div_mag, 15'b0} + {17'b0, len_r[31:1]};
          d_r       <= {len_r, 16'b0};
          q_r       <= '0;
          div_cnt_r <= '0;
          state_r   <= ST_DIV;
        end

        ST_DIV: begin
          rem_r     <= rem_nxt;
          q_r       <= q_nxt;
          d_r       <= d_r >> 1;
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'd16) begin
            case (comp_r)
              2'd0:    res_nx_r <= c_out;
              2'd1:    res_ny_r <= c_out;
              default: res_nz_r <= c_out;
            endcase
            if (comp_r == 2'd2) state_r <= ST_DONE;
            else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= ST_DLOAD;
            end
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {res_nz_r, res_ny_r, res_nx_r, res_h_r};
            out_oob_r   <= res_oob_r;
            clr_ret_r   <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oob_r;

  // checks
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_TACC))
    else $error("ram written outside a write or fill");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != ST_IDLE)
    else $error("accepted beat left the sequencer idle");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQ |-> m_r[32:30] == 3'b001)
    else $error("normal components not normalised");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> len_r[31:30] != 2'b00)
    else $error("vector length below range");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && div_cnt_r == 5'd16 |-> q_nxt <= 17'd32768)
    else $error("unit component quotient out of range");

endmodule

@@ tb/heightfield_bilinear_checker.sv @@
`timescale 1ns / 100ps

module heightfield_bilinear_checker
  import hbs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [79:0]  out_tdata,
  input  logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [31:0] height;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        oob;
  } hf_result_t;

  logic [31:0] heights [DEPTH];
  logic [8:0]  grid_reg;
  logic [31:0] tpm_reg;
  logic [31:0] mpt_reg;
  logic        enable_reg;
  hf_result_t  result_q[$];

  function automatic longint unsigned texel_coord(longint pos, int unsigned g);
    longint unsigned lim;
    lim = longint'(g - 1) << 32;
    if (pos <= 0 || tpm_reg == 0) return 0;
    if (longint'(unsigned'(pos)) > lim / tpm_reg) return lim;
    return longint'(unsigned'(pos)) * tpm_reg;
  endfunction

  function automatic longint texel(int unsigned x, int unsigned z, int unsigned g);
    return longint'($signed(heights[z * g + x]));
  endfunction

  function automatic longint bilinear(longint px, longint pz, int unsigned g);
    longint unsigned u, v;
    int unsigned x0, z0, x1, z1;
    longint tx, tz, h00, h10, h01, h11, h0, h1;
    u = texel_coord(px, g);
    v = texel_coord(pz, g);
    x0 = u[63:32];
    z0 = v[63:32];
    x1 = (x0 + 1 < g - 1) ? x0 + 1 : g - 1;
    z1 = (z0 + 1 < g - 1) ? z0 + 1 : g - 1;
    tx = longint'(u[31:16]);
    tz = longint'(v[31:16]);
    h00 = texel(x0, z0, g);
    h10 = texel(x1, z0, g);
    h01 = texel(x0, z1, g);
    h11 = texel(x1, z1, g);
    h0 = h00 + (((h10 - h00) * tx) >>> 16);
    h1 = h01 + (((h11 - h01) * tx) >>> 16);
    return h0 + (((h1 - h0) * tz) >>> 16);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] unit_part(longint unsigned mag, longint unsigned len,
                                            bit neg);
    longint unsigned c;
    c = (mag * 32768 + len / 2) / len;
    if (c > 32767) c = 32767;
    return neg ? 16'(-c) : 16'(c);
  endfunction

  function automatic hf_result_t surface_normal(longint wx, longint wz, int unsigned g);
    hf_result_t r;
    longint du, dx, dz;
    longint unsigned ax, ay, az, m, len;
    r = '0;
    du = longint'(mpt_reg);
    dx = bilinear(wx + du, wz, g) - bilinear(wx - du, wz, g);
    dz = bilinear(wx, wz + du, g) - bilinear(wx, wz - du, g);
    ax = dx < 0 ? -dx : dx;
    ay = 2 * du;
    az = dz < 0 ? -dz : dz;
    m = ax > ay ? ax : ay;
    if (az > m) m = az;
    if (m == 0) begin
      r.ny = Q15_ONE;
      return r;
    end
    while (m >= (64'd1 << 31)) begin
      ax >>= 1; ay >>= 1; az >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 30)) begin
      ax <<= 1; ay <<= 1; az <<= 1; m <<= 1;
    end
    len = int_sqrt(ax * ax + ay * ay + az * az);
    r.nx = unit_part(ax, len, dx > 0);
    r.ny = unit_part(ay, len, 1'b0);
    r.nz = unit_part(az, len, dz > 0);
    return r;
  endfunction

  function automatic hf_result_t apply_op(logic [2:0] op, logic [127:0] d);
    hf_result_t r;
    int unsigned g, x, z;
    longint wx, wz;
    bit active;
    r = '0;
    g = (grid_reg < 9'(MAX_GRID)) ? 32'(grid_reg) : MAX_GRID;
    x = 32'(d[15:0]);
    z = 32'(d[31:16]);
    wx = longint'($signed(d[95:64]));
    wz = longint'($signed(d[127:96]));
    active = enable_reg && g >= 2;
    case (op)
      OP_WRITE: begin
        if (x < g && z < g) heights[z * g + x] = d[63:32];
        else r.oob = 1'b1;
      end
      OP_READ: begin
        if (x < g && z < g) r.height = heights[z * g + x];
        else r.oob = 1'b1;
      end
      OP_FILL: begin
        for (int i = 0; i < DEPTH; i++) heights[i] = d[63:32];
      end
      OP_SAMPLE: begin
        if (active) r.height = 32'(bilinear(wx, wz, g));
      end
      OP_NORMAL: begin
        if (active) r = surface_normal(wx, wz, g);
        else r.ny = Q15_ONE;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    hf_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) heights[i] = '0;
      grid_reg   <= '0;
      tpm_reg    <= SCALE_RESET;
      mpt_reg    <= SCALE_RESET;
      enable_reg <= 1'b0;
      result_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_SIZE: grid_reg   <= cfg_data[8:0];
          CFG_TPM:       tpm_reg    <= cfg_data;
          CFG_MPT:       mpt_reg    <= cfg_data;
          CFG_ENABLE:    enable_reg <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) result_q.push_back(apply_op(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (out_tdata[31:0] !== want.height || out_tdata[47:32] !== want.nx ||
              out_tdata[63:48] !== want.ny || out_tdata[79:64] !== want.nz ||
              out_tuser[0] !== want.oob) begin
            if (out_tdata[31:0] !== want.height)
              $error("height_out: expected %h, got %h", want.height, out_tdata[31:0]);
            if (out_tdata[47:32] !== want.nx)
              $error("normal_x: expected %h, got %h", want.nx, out_tdata[47:32]);
            if (out_tdata[63:48] !== want.ny)
              $error("normal_y: expected %h, got %h", want.ny, out_tdata[63:48]);
            if (out_tdata[79:64] !== want.nz)
              $error("normal_z: expected %h, got %h", want.nz, out_tdata[79:64]);
            if (out_tuser[0] !== want.oob)
              $error("out_of_bounds: expected %b, got %b", want.oob, out_tuser[0]);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

@@ tb/tb_heightfield_bilinear_sampler.sv @@
`timescale 1ns / 100ps

module tb_heightfield_bilinear_sampler;
  import hbs_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           fail_count;
  int           pending;
  int           burst_left;
  int           grid_now;
  int           stall_mode;

  heightfield_bilinear_sampler dut (.*);

  heightfield_bilinear_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: pattern switches at random between free, random and heavy stall
  initial begin
    out_tready = 1'b0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(63) == 0) stall_mode = $urandom_range(2);
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(1));
        default: out_tready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup_field(int g, logic [31:0] tpm, logic [31:0] mpt, bit en);
    drain();
    write_reg(CFG_GRID_SIZE, 32'(g));
    write_reg(CFG_TPM, tpm);
    write_reg(CFG_MPT, mpt);
    write_reg(CFG_ENABLE, 32'(en));
    grid_now = g > MAX_GRID ? MAX_GRID : g;
  endtask

  task automatic issue(op_t op, logic [15:0] x, logic [15:0] z, logic [31:0] hv,
                       logic [31:0] wx, logic [31:0] wz);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {wz, wx, hv, z, x};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] rand_pos();
    int span;
    span = (grid_now + 2) * 65536;
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(span) - 2 * 65536;
  endfunction

  task automatic random_item();
    int sel;
    logic [15:0] x, z;
    sel = $urandom_range(99);
    if (grid_now > 0 && $urandom_range(9) != 0) begin
      x = 16'($urandom_range(grid_now - 1));
      z = 16'($urandom_range(grid_now - 1));
    end else begin
      x = 16'($urandom);
      z = 16'($urandom);
    end
    if (sel < 30)      issue(OP_WRITE, x, z, $urandom, $urandom, $urandom);
    else if (sel < 47) issue(OP_READ, x, z, $urandom, $urandom, $urandom);
    else if (sel < 72) issue(OP_SAMPLE, 16'($urandom), 16'($urandom), $urandom,
                             rand_pos(), rand_pos());
    else if (sel < 97) issue(OP_NORMAL, 16'($urandom), 16'($urandom), $urandom,
                             rand_pos(), rand_pos());
    else issue(op_t'($urandom_range(5, 7)), 16'($urandom), 16'($urandom), $urandom,
               $urandom, $urandom);
  endtask

  initial begin
    int grids[8]  = '{2, 3, 5, 16, 256, 300, 1, 0};
    logic [31:0] tpms[8] = '{32'd65536, 32'd98304, 32'hFFFF_FFFF, 32'd65536,
                             32'd300000, 32'd0, 32'd65536, 32'd40000};
    logic [31:0] mpts[8] = '{32'd65536, 32'd0, 32'd1, 32'hFFFF_FFFF,
                             32'd20000, 32'd65536, 32'd65536, 32'd131072};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    burst_left = 0;
    grid_now   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: tiny grid, edges, special cases
    setup_field(4, 32'd65536, 32'd65536, 1'b1);
    issue(OP_WRITE, 0, 0, 32'h7FFF_FFFF, 0, 0);
    issue(OP_WRITE, 3, 3, 32'h8000_0000, 0, 0);
    issue(OP_WRITE, 4, 0, 32'h1234_5678, 0, 0);
    issue(OP_WRITE, 16'hFFFF, 16'hFFFF, 32'h1111_1111, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0);
    issue(OP_READ, 3, 3, 0, 0, 0);
    issue(OP_READ, 1, 2, 0, 0, 0);
    issue(OP_READ, 0, 4, 0, 0, 0);
    issue(OP_SAMPLE, 0, 0, 0, 32'd0, 32'd0);
    issue(OP_SAMPLE, 0, 0, 0, 32'h8000_0000, 32'hFFFF_0000);
    issue(OP_SAMPLE, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue(OP_SAMPLE, 0, 0, 0, 32'h0001_8000, 32'h0000_8000);
    issue(OP_NORMAL, 0, 0, 0, 32'h0001_8000, 32'h0001_8000);
    issue(OP_NORMAL, 0, 0, 0, 32'd0, 32'd0);
    issue(OP_NORMAL, 0, 0, 0, 32'h0003_0000, 32'h0003_0000);
    issue(op_t'(3'd5), 0, 0, 0, 0, 0);
    issue(op_t'(3'd6), 0, 0, 0, 0, 0);
    issue(op_t'(3'd7), 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // flat field with zero spacing gives the degenerate normal
    setup_field(4, 32'd65536, 32'd0, 1'b1);
    issue(OP_FILL, 0, 0, 32'hFFFF_0000, 0, 0);
    issue(OP_NORMAL, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);
    issue(OP_SAMPLE, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);
    setup_field(4, 32'd65536, 32'd65536, 1'b0);
    issue(OP_SAMPLE, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);
    issue(OP_NORMAL, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);

    for (int p = 0; p < 8; p++) begin
      setup_field(grids[p], tpms[p], mpts[p], (p != 5));
      issue(OP_FILL, 0, 0, $urandom, 0, 0);
      for (int i = 0; i < 170; i++) random_item();
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
